FILE: rtl/core/cetb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circular event trace buffer package
// Shared types and constants for the trace buffer front end, command queue
// and record store.
// ----------------------------------------------------------------------------
package cetb_pkg;

  localparam int TRACE_DEPTH_DEF = 256;
  localparam int CMD_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_EVENT = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [63:0] tstamp;
    logic [31:0] code;
    logic [31:0] value;
  } rec_t;

  typedef struct packed {
    logic is_write;
    logic hit;
    logic last;
  } cmd_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/cetb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circular event trace buffer channels
// Valid/ready channels for trace input transactions and record results.
// ----------------------------------------------------------------------------
interface cetb_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] event_code;
  logic [31:0] event_value;
  logic [63:0] timestamp;

  modport source (output valid, mode, event_code, event_value, timestamp, input ready);
  modport sink   (input valid, mode, event_code, event_value, timestamp, output ready);
endinterface

interface cetb_rec_if;
  logic        valid;
  logic        ready;
  logic        rec_valid;
  logic [63:0] rec_time;
  logic [31:0] rec_event;
  logic [31:0] rec_value;
  logic        rec_last;

  modport source (output valid, rec_valid, rec_time, rec_event, rec_value, rec_last,
                  input ready);
  modport sink   (input valid, rec_valid, rec_time, rec_event, rec_value, rec_last,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cetb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trace buffer front end
// Accepts input transactions, keeps the recording and readout pointers and
// issues write and read commands to the record store.
// ----------------------------------------------------------------------------
module cetb_front
  import cetb_pkg::*;
#(
  parameter int TRACE_DEPTH = TRACE_DEPTH_DEF,
  parameter int AW          = $clog2(TRACE_DEPTH),
  parameter int LW          = $clog2(TRACE_DEPTH + 1)
) (
  input  wire logic     clk,
  input  wire logic     rst,
  cetb_evt_if.sink      evt,
  input  wire logic     q_full,
  output logic          push,
  output cmd_ctl_t      ctl,
  output logic [AW-1:0] addr,
  output rec_t          rec
);

  logic          enabled;
  logic          wrapped;
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [LW-1:0] left;

  logic          accept;
  logic [AW-1:0] wp_next;
  logic [AW-1:0] rp_next;
  logic          rd_hit;

  assign evt.ready = !q_full;
  assign accept    = evt.valid && !q_full;
  assign wp_next   = (wp == AW'(TRACE_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign rp_next   = (rp == AW'(TRACE_DEPTH - 1)) ? '0 : rp + 1'b1;
  assign rd_hit    = !enabled && (left != '0);

  always_comb begin
    push         = 1'b0;
    ctl.is_write = 1'b0;
    ctl.hit      = 1'b0;
    ctl.last     = 1'b0;
    addr         = rp;
    rec.tstamp   = evt.timestamp;
    rec.code     = evt.event_code;
    rec.value    = evt.event_value;
    unique case (mode_t'(evt.mode))
      MODE_START: begin
        push = 1'b0;
      end
      MODE_EVENT: begin
        push         = accept && enabled;
        ctl.is_write = 1'b1;
        addr         = wp;
      end
      MODE_STOP: begin
        push = 1'b0;
      end
      MODE_READ: begin
        push     = accept;
        ctl.hit  = rd_hit;
        ctl.last = rd_hit && (left == LW'(1));
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      wrapped <= 1'b0;
      wp      <= '0;
      rp      <= '0;
      left    <= '0;
    end else if (accept) begin
      unique case (mode_t'(evt.mode))
        MODE_START: begin
          enabled <= 1'b1;
          wrapped <= 1'b0;
          wp      <= '0;
          left    <= '0;
        end
        MODE_EVENT: begin
          if (enabled) begin
            wp <= wp_next;
            if (wp_next == '0) begin
              wrapped <= 1'b1;
            end
          end
        end
        MODE_STOP: begin
          enabled <= 1'b0;
          if (wrapped) begin
            rp   <= wp;
            left <= LW'(TRACE_DEPTH);
          end else begin
            rp   <= '0;
            left <= LW'(wp);
          end
        end
        MODE_READ: begin
          if (rd_hit) begin
            rp   <= rp_next;
            left <= left - 1'b1;
          end
        end
        default: begin
          enabled <= enabled;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cetb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trace buffer command queue
// Short first-in first-out queue between the front end and the record store.
// ----------------------------------------------------------------------------
module cetb_queue
  import cetb_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = CMD_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  not_empty,
  output logic                  full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign not_empty = (count != '0);
  assign full      = (count == CW'(DEPTH));
  assign rdata     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cetb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trace buffer record store
// Holds the trace ring, carries out queued write and read commands and
// registers each record result.
// ----------------------------------------------------------------------------
module cetb_back
  import cetb_pkg::*;
#(
  parameter int TRACE_DEPTH = TRACE_DEPTH_DEF,
  parameter int AW          = $clog2(TRACE_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire cmd_ctl_t      q_ctl,
  input  wire logic [AW-1:0] q_addr,
  input  wire rec_t          q_rec,
  output logic               pop,
  cetb_rec_if.source         res
);

  rec_t mem [TRACE_DEPTH];
  rec_t rd_rec;
  logic out_valid;
  logic out_hit;
  logic out_last;

  assign pop = q_valid && (q_ctl.is_write || !out_valid || res.ready);

  always_ff @(posedge clk) begin
    if (pop && q_ctl.is_write) begin
      mem[q_addr] <= q_rec;
    end
    if (pop && !q_ctl.is_write && q_ctl.hit) begin
      rd_rec <= mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_hit   <= 1'b0;
      out_last  <= 1'b0;
    end else if (pop && !q_ctl.is_write) begin
      out_valid <= 1'b1;
      out_hit   <= q_ctl.hit;
      out_last  <= q_ctl.last;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid     = out_valid;
  assign res.rec_valid = out_hit;
  assign res.rec_time  = out_hit ? rd_rec.tstamp : '0;
  assign res.rec_event = out_hit ? rd_rec.code : '0;
  assign res.rec_value = out_hit ? rd_rec.value : '0;
  assign res.rec_last  = out_hit && out_last;

endmodule

`default_nettype wire

FILE: rtl/core/circular_event_trace_buffer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circular event trace buffer
// Records timestamped events into a ring and reads them back oldest-first.
// ----------------------------------------------------------------------------
// Takes one input transaction per clock while the queue has room. Start, stop
// and event transactions give no result; an event is written to the ring if
// recording. Each read gives one result transaction, at the earliest on the
// cycle after the read reaches the record store, set by the registered read of
// the ring memory. A four-entry command queue sits between the front end and
// the store, so input ready drops only after results have been held back long
// enough to fill it. Reads with nothing left, or while recording, return
// rec_valid low with all record fields zero. No clearing pass after reset.
// ----------------------------------------------------------------------------
module circular_event_trace_buffer_unit
  import cetb_pkg::*;
#(
  parameter int TRACE_DEPTH = TRACE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cetb_evt_if.sink   evt_ch,
  cetb_rec_if.source rec_ch
);

  localparam int AW = $clog2(TRACE_DEPTH);
  localparam int LW = $clog2(TRACE_DEPTH + 1);
  localparam int QW = $bits(cmd_ctl_t) + AW + $bits(rec_t);

  logic          push;
  cmd_ctl_t      f_ctl;
  logic [AW-1:0] f_addr;
  rec_t          f_rec;
  logic          q_full;
  logic          q_valid;
  logic          pop;
  logic [QW-1:0] q_data;
  cmd_ctl_t      q_ctl;
  logic [AW-1:0] q_addr;
  rec_t          q_rec;

  cetb_front #(
    .TRACE_DEPTH (TRACE_DEPTH),
    .AW          (AW),
    .LW          (LW)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .evt    (evt_ch),
    .q_full (q_full),
    .push   (push),
    .ctl    (f_ctl),
    .addr   (f_addr),
    .rec    (f_rec)
  );

  cetb_queue #(
    .WIDTH (QW),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     ({f_ctl, f_addr, f_rec}),
    .pop       (pop),
    .rdata     (q_data),
    .not_empty (q_valid),
    .full      (q_full)
  );

  assign {q_ctl, q_addr, q_rec} = q_data;

  cetb_back #(
    .TRACE_DEPTH (TRACE_DEPTH),
    .AW          (AW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ctl   (q_ctl),
    .q_addr  (q_addr),
    .q_rec   (q_rec),
    .pop     (pop),
    .res     (rec_ch)
  );

endmodule

`default_nettype wire
